// ----- rtl/core/cfs_pkg.sv -----
// cfs_pkg: shared constants, register indexes and the queue entry type
// for the camera frame scaler; no dependencies
`default_nettype none

package cfs_pkg;

	// default coordinate counter width
	localparam int COORD_WIDTH = 12;

	// configuration port
	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE      = 3'd4;

	// reset values of the registers
	localparam logic [CFG_W-1:0] RST_SRC_WIDTH      = 12'd320;
	localparam logic [CFG_W-1:0] RST_SRC_HEIGHT     = 12'd240;
	localparam logic [CFG_W-1:0] RST_DISPLAY_WIDTH  = 12'd160;
	localparam logic [CFG_W-1:0] RST_DISPLAY_HEIGHT = 12'd128;

	// luminance weights, sum scaled by 256
	localparam logic [7:0] LUMA_R = 8'd77;
	localparam logic [7:0] LUMA_G = 8'd150;
	localparam logic [7:0] LUMA_B = 8'd29;

	// pixel queue between selection and conversion
	localparam int QUEUE_DEPTH = 4;

	// one kept pixel waiting for conversion
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pix_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfs_front.sv -----
// cfs_front: source/destination counters and running sums that decide which
// camera pixels are kept; uses cfs_pkg
`default_nettype none

module cfs_front #(
	parameter int COORD_WIDTH = cfs_pkg::COORD_WIDTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [cfs_pkg::CFG_W-1:0]     src_width,
	input  wire  [cfs_pkg::CFG_W-1:0]     src_height,
	input  wire  [cfs_pkg::CFG_W-1:0]     display_width,
	input  wire  [cfs_pkg::CFG_W-1:0]     display_height,
	input  wire                           accept,
	output logic                          keep,
	output logic                          last
);

	localparam int CW = COORD_WIDTH;
	localparam int SW = 2 * COORD_WIDTH;
	localparam int EW = (CW > cfs_pkg::CFG_W) ? CW : cfs_pkg::CFG_W;
	localparam logic [EW-1:0] CMAX = EW'({CW{1'b1}});

	// zero reads as one, oversize saturates to the counter range
	function automatic logic [CW-1:0] eff_size(input logic [cfs_pkg::CFG_W-1:0] v);
		logic [EW-1:0] x;
		x = EW'(v);
		if (x == '0)
			x = EW'(1);
		else if (x > CMAX)
			x = CMAX;
		return x[CW-1:0];
	endfunction

	logic [CW-1:0] fw, fh, dw_e, dh_e, dw, dh;
	logic [CW-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [SW-1:0] col_tgt_q, col_src_q, row_tgt_q, row_src_q;
	logic          row_sel, col_sel, row_end, frame_end;

	// effective sizes, display clamped to frame
	always_comb begin
		fw   = eff_size(src_width);
		fh   = eff_size(src_height);
		dw_e = eff_size(display_width);
		dh_e = eff_size(display_height);
		dw   = (dw_e > fw) ? fw : dw_e;
		dh   = (dh_e > fh) ? fh : dh_e;
	end

	// selection, last-pixel flag and end-of-row and end-of-frame detection
	always_comb begin
		row_sel = (dst_row_q < dh) &&
			({1'b0, row_tgt_q} < ({1'b0, row_src_q} + (SW+1)'(dh)));
		col_sel = (dst_col_q < dw) &&
			({1'b0, col_tgt_q} < ({1'b0, col_src_q} + (SW+1)'(dw)));
		keep      = row_sel && col_sel;
		last      = (dst_col_q == dw - CW'(1)) && (dst_row_q == dh - CW'(1));
		row_end   = ({1'b0, src_col_q} + (CW+1)'(1)) >= {1'b0, fw};
		frame_end = row_end && (({1'b0, src_row_q} + (CW+1)'(1)) >= {1'b0, fh});
	end

	// counter and sum update per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			col_tgt_q <= '0;
			col_src_q <= '0;
			row_tgt_q <= '0;
			row_src_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				src_col_q <= '0;
				dst_col_q <= '0;
				col_tgt_q <= '0;
				col_src_q <= '0;
				if (frame_end) begin
					src_row_q <= '0;
					dst_row_q <= '0;
					row_tgt_q <= '0;
					row_src_q <= '0;
				end else begin
					src_row_q <= src_row_q + CW'(1);
					row_src_q <= row_src_q + SW'(dh);
					if (row_sel) begin
						dst_row_q <= dst_row_q + CW'(1);
						row_tgt_q <= row_tgt_q + SW'(fh);
					end
				end
			end else begin
				src_col_q <= src_col_q + CW'(1);
				col_src_q <= col_src_q + SW'(dw);
				if (keep) begin
					dst_col_q <= dst_col_q + CW'(1);
					col_tgt_q <= col_tgt_q + SW'(fw);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cfs_queue.sv -----
// cfs_queue: small register queue of kept pixels between selection and
// conversion; uses cfs_pkg
`default_nettype none

module cfs_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  cfs_pkg::pix_t  push_data,
	output logic           full,
	output logic           nonempty,
	input  wire            pop,
	output cfs_pkg::pix_t  head
);

	localparam int D  = cfs_pkg::QUEUE_DEPTH;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CNTW = $clog2(D + 1);

	cfs_pkg::pix_t   mem_q [D];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = (cnt_q == CNTW'(D));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	// pointer wrap at depth
	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(D - 1)) ? '0 : p + AW'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= next_ptr(wr_q);
			if (pop)
				rd_q <= next_ptr(rd_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/cfs_back.sv -----
// cfs_back: color or grey conversion to RGB565 and the output register;
// uses cfs_pkg
`default_nettype none

module cfs_back (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            gray_mode,
	input  wire            nonempty,
	input  cfs_pkg::pix_t  head,
	output logic           pop,
	output logic           out_valid,
	input  wire            out_ready,
	output logic [15:0]    color,
	output logic           frame_last
);

	logic        out_valid_q;
	logic [15:0] color_q;
	logic        last_q;
	logic [15:0] luma_sum;
	logic [7:0]  luma;
	logic [15:0] packed_px;

	// output register takes a new pixel when empty or being drained
	assign pop = nonempty && (!out_valid_q || out_ready);

	// luminance and rgb565 packing
	always_comb begin
		luma_sum = 16'(head.red) * 16'(cfs_pkg::LUMA_R)
			+ 16'(head.green) * 16'(cfs_pkg::LUMA_G)
			+ 16'(head.blue) * 16'(cfs_pkg::LUMA_B);
		luma = luma_sum[15:8];
		if (gray_mode)
			packed_px = {luma[7:3], luma[7:2], luma[7:3]};
		else
			packed_px = {head.red[7:3], head.green[7:2], head.blue[7:3]};
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			color_q <= packed_px;
			last_q  <= head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign color      = color_q;
	assign frame_last = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/camera_frame_scaler_rgb565.sv -----
// camera_frame_scaler_rgb565: nearest-neighbor downscaler, camera pixels in,
// RGB565 out; uses cfs_pkg, cfs_front, cfs_queue, cfs_back
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   input   | in_valid, in_ready, blue, green, red  | in
//   output  | out_valid, out_ready, color,          | out
//           | frame_last                            |
//   config  | cfg_wen, cfg_index, cfg_data          | in
//
// one camera pixel per clock while in_ready is high; a kept pixel is written
// to the pixel queue when it is accepted and is loaded from the queue into the
// output register, raising out_valid, once that register is empty or drained
// the selection counters and sums update once per accepted item
// in_ready drops only when the four-entry pixel queue is full
// arst_n clears counters, sums, queue and output valid and loads the
// default frame 320x240 to display 160x128 in color
`default_nettype none

module camera_frame_scaler_rgb565 #(
	parameter int COORD_WIDTH = cfs_pkg::COORD_WIDTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wen,
	input  wire  [cfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [cfs_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [7:0]                       blue,
	input  wire  [7:0]                       green,
	input  wire  [7:0]                       red,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [15:0]                      color,
	output logic                             frame_last
);

	logic [cfs_pkg::CFG_W-1:0] src_width_q, src_height_q;
	logic [cfs_pkg::CFG_W-1:0] display_width_q, display_height_q;
	logic                      gray_mode_q;

	logic          accept, keep, last, full, nonempty, pop;
	cfs_pkg::pix_t push_data, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q      <= cfs_pkg::RST_SRC_WIDTH;
			src_height_q     <= cfs_pkg::RST_SRC_HEIGHT;
			display_width_q  <= cfs_pkg::RST_DISPLAY_WIDTH;
			display_height_q <= cfs_pkg::RST_DISPLAY_HEIGHT;
			gray_mode_q      <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				cfs_pkg::REG_SRC_WIDTH:      src_width_q      <= cfg_data;
				cfs_pkg::REG_SRC_HEIGHT:     src_height_q     <= cfg_data;
				cfs_pkg::REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data;
				cfs_pkg::REG_DISPLAY_HEIGHT: display_height_q <= cfg_data;
				cfs_pkg::REG_GRAY_MODE:      gray_mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push_data.red   = red;
		push_data.green = green;
		push_data.blue  = blue;
		push_data.last  = last;
	end

	cfs_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.src_width      (src_width_q),
		.src_height     (src_height_q),
		.display_width  (display_width_q),
		.display_height (display_height_q),
		.accept         (accept),
		.keep           (keep),
		.last           (last)
	);

	cfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && keep),
		.push_data (push_data),
		.full      (full),
		.nonempty  (nonempty),
		.pop       (pop),
		.head      (head)
	);

	cfs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gray_mode  (gray_mode_q),
		.nonempty   (nonempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.color      (color),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for camera_frame_scaler_rgb565, downscale selection
// and rgb565 / grey conversion checked against an in-bench scaler model
// depends on cfs_pkg and the rtl of camera_frame_scaler_rgb565
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1050;
	localparam int CALM_FROM      = 900;
	localparam int CW             = cfs_pkg::COORD_WIDTH;
	localparam int CFG_W          = cfs_pkg::CFG_W;
	localparam int CFG_IDX_W      = cfs_pkg::CFG_IDX_W;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} camera_px_t;

	typedef struct packed {
		logic [15:0] color;
		logic        frame_last;
	} rgb565_px_t;

	// dut ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           blue = '0;
	logic [7:0]           green = '0;
	logic [7:0]           red = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [15:0]          color;
	logic                 frame_last;

	// stimulus and expectations
	camera_px_t camera_feed[$];
	rgb565_px_t pending_pixels[$];
	camera_px_t next_px;
	rgb565_px_t want_px;
	int         in_gap = 0;
	int         out_gap = 0;
	bit         in_idle_on = 1'b0;
	bit         out_idle_on = 1'b0;
	int         fail_count = 0;
	int         quiet_cycles = 0;

	// shadow of the configuration registers
	logic [CFG_W-1:0] frame_w = cfs_pkg::RST_SRC_WIDTH;
	logic [CFG_W-1:0] frame_h = cfs_pkg::RST_SRC_HEIGHT;
	logic [CFG_W-1:0] disp_w = cfs_pkg::RST_DISPLAY_WIDTH;
	logic [CFG_W-1:0] disp_h = cfs_pkg::RST_DISPLAY_HEIGHT;
	logic             gray_on = 1'b0;

	// scaler position and selection accumulators
	logic [CW-1:0]   src_col = '0;
	logic [CW-1:0]   src_row = '0;
	logic [CW-1:0]   dst_col = '0;
	logic [CW-1:0]   dst_row = '0;
	logic [2*CW-1:0] col_dst_acc = '0;
	logic [2*CW-1:0] col_src_acc = '0;
	logic [2*CW-1:0] row_dst_acc = '0;
	logic [2*CW-1:0] row_src_acc = '0;

	camera_frame_scaler_rgb565 i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.color      (color),
		.frame_last (frame_last)
	);

	// a size register of zero counts as one
	function automatic logic [31:0] eff_dim(input logic [CFG_W-1:0] v);
		return (v == '0) ? 32'd1 : 32'(v);
	endfunction

	// select and convert one camera pixel, queue the display pixel it yields
	task automatic scale_pixel(input camera_px_t px);
		logic [31:0] fw;
		logic [31:0] fh;
		logic [31:0] dw;
		logic [31:0] dh;
		logic [31:0] luma;
		logic        row_hit;
		logic        col_hit;
		rgb565_px_t  res;
		fw = eff_dim(frame_w);
		fh = eff_dim(frame_h);
		dw = eff_dim(disp_w);
		dh = eff_dim(disp_h);
		if (dw > fw) begin
			dw = fw;
		end
		if (dh > fh) begin
			dh = fh;
		end
		row_hit = (32'(dst_row) < dh) && (32'(row_dst_acc) < 32'(row_src_acc) + dh);
		col_hit = (32'(dst_col) < dw) && (32'(col_dst_acc) < 32'(col_src_acc) + dw);

		// kept pixel
		if (row_hit && col_hit) begin
			if (gray_on) begin
				luma = 32'(px.red) * 32'(cfs_pkg::LUMA_R)
					+ 32'(px.green) * 32'(cfs_pkg::LUMA_G)
					+ 32'(px.blue) * 32'(cfs_pkg::LUMA_B);
				res.color = {luma[15:11], luma[15:10], luma[15:11]};
			end else begin
				res.color = {px.red[7:3], px.green[7:2], px.blue[7:3]};
			end
			res.frame_last = (32'(dst_col) == dw - 1) && (32'(dst_row) == dh - 1);
			pending_pixels.push_back(res);
			dst_col = dst_col + 1'b1;
			col_dst_acc = col_dst_acc + fw[2*CW-1:0];
		end

		// advance the source position, wrap at row and frame end
		if (32'(src_col) + 1 >= fw) begin
			src_col = '0;
			dst_col = '0;
			col_dst_acc = '0;
			col_src_acc = '0;
			if (32'(src_row) + 1 >= fh) begin
				src_row = '0;
				dst_row = '0;
				row_dst_acc = '0;
				row_src_acc = '0;
			end else begin
				src_row = src_row + 1'b1;
				row_src_acc = row_src_acc + dh[2*CW-1:0];
				if (row_hit) begin
					dst_row = dst_row + 1'b1;
					row_dst_acc = row_dst_acc + fh[2*CW-1:0];
				end
			end
		end else begin
			src_col = src_col + 1'b1;
			col_src_acc = col_src_acc + dw[2*CW-1:0];
		end
	endtask

	// clock generation
	initial begin
		forever #5 clk = ~clk;
	end

	// camera side: presents items from the feed, random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				scale_pixel({blue, green, red});
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (in_idle_on && $urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					in_gap <= $urandom_range(0, 8);
				end else if (camera_feed.size() != 0) begin
					next_px = camera_feed.pop_front();
					in_valid <= 1'b1;
					blue <= next_px.blue;
					green <= next_px.green;
					red <= next_px.red;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// display side: checks each item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$error("unexpected item: color %h frame_last %b", color, frame_last);
					fail_count++;
				end else begin
					want_px = pending_pixels.pop_front();
					if (color !== want_px.color) begin
						$error("color: expected %h, actual %h", want_px.color, color);
						fail_count++;
					end
					if (frame_last !== want_px.frame_last) begin
						$error("frame_last: expected %b, actual %b",
							want_px.frame_last, frame_last);
						fail_count++;
					end
				end
			end
			// stall bursts
			if (out_gap != 0) begin
				out_ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				out_gap <= $urandom_range(0, 8);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one register write per clock
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			cfs_pkg::REG_SRC_WIDTH:      frame_w = value;
			cfs_pkg::REG_SRC_HEIGHT:     frame_h = value;
			cfs_pkg::REG_DISPLAY_WIDTH:  disp_w = value;
			cfs_pkg::REG_DISPLAY_HEIGHT: disp_h = value;
			cfs_pkg::REG_GRAY_MODE:      gray_on = value[0];
			default: ;
		endcase
	endtask

	// write the whole register set, upper gray_mode bits carry junk
	task automatic setup_scaler(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] fh,
		input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh, input logic gray);
		write_reg(cfs_pkg::REG_SRC_WIDTH, fw);
		write_reg(cfs_pkg::REG_SRC_HEIGHT, fh);
		write_reg(cfs_pkg::REG_DISPLAY_WIDTH, dw);
		write_reg(cfs_pkg::REG_DISPLAY_HEIGHT, dh);
		write_reg(cfs_pkg::REG_GRAY_MODE, {11'($urandom_range(0, 2047)), gray});
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// wait until the block has taken and returned everything
	task automatic drain();
		do begin
			@(negedge clk);
		end while (camera_feed.size() != 0 || in_valid || pending_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		camera_feed.push_back({b, g, r});
	endtask

	task automatic add_pixels(input int n);
		repeat (n) begin
			add_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
	endtask

	// feed the rest of the frame in progress when that is short
	task automatic complete_frame(output int n);
		logic [31:0] fw;
		logic [31:0] fh;
		fw = eff_dim(frame_w);
		fh = eff_dim(frame_h);
		n = 0;
		if (32'(src_col) < fw && 32'(src_row) < fh && (src_col != 0 || src_row != 0)) begin
			n = (fh - 1 - 32'(src_row)) * fw + (fw - 32'(src_col));
			if (n > 300) begin
				n = 0;
			end
			add_pixels(n);
		end
	endtask

	// display size: mostly a downscale, sometimes zero, full size or an upscale request
	function automatic logic [CFG_W-1:0] pick_display(input int src);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_W'(src + $urandom_range(1, 8));
			2: return CFG_W'(src);
			3: return '1;
			default: return CFG_W'($urandom_range(1, src));
		endcase
	endfunction

	// test sequence
	initial begin
		int random_items;
		int phase_no;
		int fw;
		int fh;
		int n;
		random_items = 0;
		phase_no = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults, color extremes
		add_pixel(8'h00, 8'h00, 8'h00);
		add_pixel(8'hff, 8'hff, 8'hff);
		add_pixel(8'h00, 8'h00, 8'hff);
		add_pixel(8'hff, 8'h00, 8'h00);
		drain();

		// zero sizes act as 1x1 in grey, stale display column drops the first item
		setup_scaler('0, '0, '0, '0, 1'b1);
		add_pixel(8'hff, 8'hff, 8'hff);
		add_pixel(8'hff, 8'hff, 8'hff);
		add_pixel(8'h00, 8'h00, 8'h00);
		add_pixel(8'h00, 8'hff, 8'h00);
		drain();

		// upscale request clamped to the frame, one whole frame
		setup_scaler(12'd3, 12'd2, 12'd10, '1, 1'b0);
		add_pixel(8'h00, 8'hff, 8'h00);
		add_pixel(8'hff, 8'h00, 8'hff);
		add_pixels(4);
		drain();

		// downscale cut mid-frame, then a narrower display mid-row
		setup_scaler(12'd8, 12'd2, 12'd3, 12'd1, 1'b1);
		add_pixels(5);
		drain();
		setup_scaler(12'd8, 12'd2, 12'd1, 12'd1, 1'b0);
		add_pixels(6);
		drain();

		// random phases, mostly whole frames
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= CALM_FROM) begin
				in_idle_on = 1'b0;
				out_idle_on = 1'b0;
			end else begin
				in_idle_on = ($urandom_range(0, 3) != 0);
				out_idle_on = ($urandom_range(0, 3) != 0);
			end
			if (phase_no == 0) begin
				setup_scaler('1, '1, '1, '1, 1'($urandom_range(0, 1)));
				add_pixels(24);
				random_items += 24;
			end else if (phase_no == 1) begin
				setup_scaler('1, '1, 12'd1, 12'd1, 1'($urandom_range(0, 1)));
				add_pixels(20);
				random_items += 20;
			end else begin
				if ($urandom_range(0, 4) != 0) begin
					complete_frame(n);
					random_items += n;
					drain();
				end
				fw = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
				fh = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
				setup_scaler(CFG_W'(fw), CFG_W'(fh), pick_display(fw), pick_display(fh),
					1'($urandom_range(0, 1)));
				if ($urandom_range(0, 4) == 0) begin
					// broken frame, reconfigured while in progress
					n = $urandom_range(1, (fw * fh > 150) ? 150 : fw * fh);
				end else begin
					n = fw * fh * $urandom_range(1, 3);
					if (n > 150) begin
						n = 150;
					end
				end
				add_pixels(n);
				random_items += n;
			end
			phase_no++;
			drain();
		end

		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
